### hw/rtl/ovl_pkg.sv
// Shared types and codes for the ordered value list.
package ovl_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // per-cell control: cell holds a live entry, cell is the tail slot to write
    typedef struct packed {
        logic active;
        logic tail_wr;
    } cell_ctl_t;

    // control shared by every cell: compare against the request value, shift on hit
    typedef struct packed {
        logic check;
        logic shift;
    } op_ctl_t;

endpackage

### hw/rtl/ovl_cell.sv
// One storage cell of the ordered value list.
module ovl_cell
    import ovl_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t cell_ctl,
    input  op_ctl_t   op_ctl,
    input  value_t    value,
    input  value_t    shift_data,
    input  logic      hit_in,
    output logic      hit_out,
    output value_t    entry_out
);

    value_t entry_reg;

    // a hit here or anywhere closer to the head
    assign hit_out   = hit_in | (op_ctl.check & cell_ctl.active & (entry_reg == value));
    assign entry_out = entry_reg;

    always_ff @(posedge aclk) begin
        if (cell_ctl.tail_wr) begin
            entry_reg <= value;
        end else if (op_ctl.shift && hit_out) begin
            // take the neighbor's entry to close the gap
            entry_reg <= shift_data;
        end
    end

endmodule

### hw/rtl/ordered_value_list.sv
// Top level of the ordered value list: a chain of cells with a count register.
//
// ordered_value_list keeps up to DEPTH signed 32-bit values in insertion order in a row of
// identical cells, entry 0 at the head. Each request item carries an operation and a value:
// append writes the tail cell (status full when no room), search compares every live cell
// at once, remove drops the first matching entry and pop drops the head; in both drop
// cases every cell behind the dropped one takes its neighbor's entry in the same cycle, so
// order is kept. A hit chain runs from the head through the cells so that only the first
// match counts. Every request gives exactly one result item with found, the popped head
// value (zero otherwise), a status code, the count after the operation (low five bits)
// and an empty flag. The cell compare, the hit chain and the count update all finish in
// the accept cycle, and the result lands in an output register. A new item is taken in
// every cycle while that register is empty or being drained. Cell contents are not cleared
// by reset; only the count and the output valid flag are, and cells beyond the count are
// never compared or returned.
module ordered_value_list
    import ovl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  value_t             s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output value_t             m_head_value,
    output logic [1:0]         m_status,
    output logic [COUNT_W-1:0] m_entry_count,
    output logic               m_is_empty
);

    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             m_valid_reg;
    logic             found_reg;
    value_t           head_reg;
    logic [1:0]       status_reg;
    logic [OCC_W-1:0] count_reg;

    logic    accept;
    logic    full;
    logic    empty;
    logic    do_append;
    logic    do_pop;
    logic    found;
    op_ctl_t op_ctl;

    logic   hit  [DEPTH+1];
    value_t entry[DEPTH];

    // hold the result until taken; accept the next item in the same cycle it drains
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign full  = (occ_reg == OCC_W'(DEPTH));
    assign empty = (occ_reg == '0);

    assign do_append = accept && (s_operation == OP_APPEND) && !full;
    assign do_pop    = (s_operation == OP_POP) && !empty;

    // search and remove compare; remove and pop shift the cells behind the hit
    assign op_ctl.check = (s_operation == OP_SEARCH) || (s_operation == OP_REMOVE);
    assign op_ctl.shift = accept && ((s_operation == OP_REMOVE) || (s_operation == OP_POP));

    // a pop starts the hit chain at the head
    assign hit[0] = do_pop;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_ctl_t cell_ctl;
        value_t    shift_data;

        assign cell_ctl.active  = (OCC_W'(i) < occ_reg);
        assign cell_ctl.tail_wr = do_append && (occ_reg == OCC_W'(i));

        if (i == DEPTH - 1) begin : g_last
            assign shift_data = entry[i];
        end else begin : g_mid
            assign shift_data = entry[i+1];
        end

        ovl_cell u_cell (
            .aclk      (aclk),
            .cell_ctl  (cell_ctl),
            .op_ctl    (op_ctl),
            .value     (s_value),
            .shift_data(shift_data),
            .hit_in    (hit[i]),
            .hit_out   (hit[i+1]),
            .entry_out (entry[i])
        );
    end

    assign found = hit[DEPTH];

    // advance the count: grow on append, shrink on any drop
    always_comb begin
        occ_next = occ_reg;
        if (do_append) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (op_ctl.shift && found) begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            found_reg <= found;
            count_reg <= occ_next;
            head_reg  <= do_pop ? entry[0] : '0;
            case (s_operation)
                OP_APPEND: status_reg <= full ? ST_FULL : ST_OK;
                OP_POP:    status_reg <= empty ? ST_EMPTY : ST_OK;
                default:   status_reg <= ST_OK;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_head_value  = head_reg;
    assign m_status      = status_reg;
    assign m_entry_count = COUNT_W'(count_reg);
    assign m_is_empty    = (count_reg == '0);

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(DEPTH))
        else $error("entry count beyond list depth");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_append |=> (occ_reg == $past(occ_reg) + OCC_W'(1)))
        else $error("append did not grow the list");

    a_full_no_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> !m_found)
        else $error("full result reports a match");

    a_drop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_ctl.shift && found) |=> (occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("drop did not shrink the list");

endmodule
